@@ sv/spsm_pkg.sv @@
// ----------------------------------------------------------------------------
// spsm_pkg: shared types and constants of the substring matcher
// Pattern storage layout, register indexes, match modes and the ASCII
// case-folding function that the cells call.
// ----------------------------------------------------------------------------
`default_nettype none

package spsm_pkg;

   // Pattern storage is always sixteen bytes wide.
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_W     = PATTERN_BYTES * 8;
   localparam int LENGTH_W      = 5;
   localparam int PIDX_W        = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   // ASCII folding constants.
   localparam logic [7:0] FOLD_OFFSET = 8'h20;
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_MATCH_MODE     = 3'd3,
      CSR_FOLD_CASE      = 3'd4
   } csr_index_type;

   // Match modes; the unused code never matches.
   typedef enum logic [1:0] {
      MODE_CONTAINS = 2'd0,
      MODE_STARTS   = 2'd1,
      MODE_ENDS     = 2'd2
   } mode_type;

   // Compare settings broadcast to every cell of the row.
   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [LENGTH_W-1:0]  length;
      logic                 fold_case;
   } cmp_cfg_type;

   // Maps A-Z to a-z when folding is enabled.
   function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
      if (en && (c inside {[UPPER_FIRST:UPPER_LAST]})) begin
         return c + FOLD_OFFSET;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/spsm_intf.sv @@
// ----------------------------------------------------------------------------
// spsm_intf: handshake channels of the substring matcher
// Byte request channel, match response channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface spsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       is_last;

   modport source (output valid, output in_char, output is_last, input ready);
   modport sink   (input valid, input in_char, input is_last, output ready);
endinterface

interface spsm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source (output valid, output matched, input ready);
   modport sink   (input valid, input matched, output ready);
endinterface

interface spsm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [spsm_pkg::CSR_INDEX_W-1:0] index;
   logic [spsm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/spsm_cell.sv @@
// ----------------------------------------------------------------------------
// spsm_cell: one window position of the matcher row
// Holds one string byte, passes it to the next cell on every transfer and
// compares the incoming byte against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module spsm_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  shift,
   input  wire logic                  clear,
   input  wire logic [7:0]            byte_in,
   output      logic [7:0]            byte_out,
   input  wire spsm_pkg::cmp_cfg_type cfg,
   output      logic                  byte_ok
);

   localparam logic [spsm_pkg::LENGTH_W-1:0] INDEX_C = spsm_pkg::LENGTH_W'(INDEX);

   logic [7:0]                    window_ff;
   logic [7:0]                    window_in;
   logic                          active;
   logic [spsm_pkg::LENGTH_W-1:0] pidx_full;
   logic [spsm_pkg::PIDX_W-1:0]   pidx;
   logic [7:0]                    pattern_byte;

   // Shift in the neighbor's byte; the last byte of a string empties the cell.
   always_comb begin
      window_in = window_ff;
      if (shift) begin
         window_in = clear ? 8'h00 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 8'h00;
      end else begin
         window_ff <= window_in;
      end
   end

   assign byte_out = window_ff;

   // This cell faces pattern byte length-1-INDEX when it lies inside the pattern.
   assign active       = INDEX_C < cfg.length;
   assign pidx_full    = cfg.length - INDEX_C - 5'd1;
   assign pidx         = pidx_full[spsm_pkg::PIDX_W-1:0];
   assign pattern_byte = cfg.pattern[{pidx, 3'b000} +: 8];

   // Compare the incoming byte, which this cell stores unless it ends a string.
   assign byte_ok = !active ||
      (spsm_pkg::fold(byte_in, cfg.fold_case) == spsm_pkg::fold(pattern_byte, cfg.fold_case));

endmodule

`default_nettype wire

@@ sv/substring_prefix_suffix_matcher_unit.sv @@
// The match for a string appears in the cycle after its last byte transfers.
// Throughput: one byte per cycle while no result is held; all cells compare in parallel.
// A result still waiting in the output register holds off input until the sink takes it.
// Reset clears the window, byte count, found flag, pending result and all
// configuration registers to zero.
// ----------------------------------------------------------------------------
// substring_prefix_suffix_matcher_unit: streaming pattern matcher
// Tests a byte stream against a configured pattern (contains, starts with,
// ends with) with optional ASCII case folding, using a row of window cells.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_prefix_suffix_matcher_unit #(
   parameter int PATTERN_MAX = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   spsm_req_if.sink    req_if,
   spsm_rsp_if.source  rsp_if,
   spsm_csr_if.sink    csr_if
);

   localparam int CNT_W = $clog2(PATTERN_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PATTERN_MAX);
   localparam logic [5:0]       MAX_WIDE = 6'(PATTERN_MAX);

   // Configuration registers.
   logic [63:0]                   pattern_low_ff;
   logic [63:0]                   pattern_high_ff;
   logic [spsm_pkg::LENGTH_W-1:0] length_ff;
   logic [1:0]                    mode_ff;
   logic                          fold_ff;

   // String state and response registers.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             found_ff;
   logic             found_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_matched_ff;
   logic             rsp_matched_in;

   logic                  accept;
   logic                  last;
   spsm_pkg::cmp_cfg_type cfg;
   logic [7:0]            chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_ok;
   logic [5:0]            count_wide;
   logic [5:0]            old_plus_one;
   logic [5:0]            length_wide;
   logic                  enough;
   logic                  hit;
   logic                  result;

   // Register writes are always taken.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         length_ff       <= '0;
         mode_ff         <= '0;
         fold_ff         <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            spsm_pkg::CSR_PATTERN_LOW:    pattern_low_ff  <= csr_if.data;
            spsm_pkg::CSR_PATTERN_HIGH:   pattern_high_ff <= csr_if.data;
            spsm_pkg::CSR_PATTERN_LENGTH: length_ff <= csr_if.data[spsm_pkg::LENGTH_W-1:0];
            spsm_pkg::CSR_MATCH_MODE:     mode_ff   <= csr_if.data[1:0];
            spsm_pkg::CSR_FOLD_CASE:      fold_ff   <= csr_if.data[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.pattern   = {pattern_high_ff, pattern_low_ff};
   assign cfg.length    = length_ff;
   assign cfg.fold_case = fold_ff;

   // Input transfer; a pending result only stalls when it is itself held.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign last         = req_if.is_last;

   // Row of window cells, newest byte in cell zero.
   for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
      logic [7:0] cell_in;
      if (gi == 0) begin : g_head
         assign cell_in = req_if.in_char;
      end else begin : g_body
         assign cell_in = chain[gi-1];
      end
      spsm_cell #(
         .INDEX (gi)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (accept),
         .clear    (last),
         .byte_in  (cell_in),
         .byte_out (chain[gi]),
         .cfg      (cfg),
         .byte_ok  (cell_ok[gi])
      );
   end

   // Saturating byte count including the incoming byte.
   always_comb begin
      count_in = count_ff;
      if (count_ff < CNT_MAX) begin
         count_in = count_ff + 1'b1;
      end
   end

   assign count_wide   = 6'(count_in);
   assign old_plus_one = 6'(count_ff) + 6'd1;
   assign length_wide  = 6'(length_ff);
   assign enough       = (length_ff != '0) && (length_wide <= MAX_WIDE) &&
                         (count_wide >= length_wide);
   assign hit          = enough && (&cell_ok);

   // Sticky found flag and the result for the current byte.
   always_comb begin
      found_in = found_ff;
      result   = 1'b0;
      case (mode_ff)
         spsm_pkg::MODE_CONTAINS: begin
            found_in = found_ff || hit;
            result   = found_in;
         end
         spsm_pkg::MODE_STARTS: begin
            found_in = found_ff || (hit && (old_plus_one == length_wide));
            result   = found_in;
         end
         spsm_pkg::MODE_ENDS: begin
            result = hit;
         end
         default: begin
            result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= last ? '0 : count_in;
         found_ff <= last ? 1'b0 : found_in;
      end
   end

   // Output register: loaded on a last byte, emptied when the sink takes it.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (accept && last) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.matched = rsp_matched_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_substring_prefix_suffix_matcher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_substring_prefix_suffix_matcher_unit: self-checking bench of the matcher
// Streams strings byte by byte through the matcher under random idling on both
// channels and compares each result with a behavioral predictor or a preset.
// A short directed table covers reset values, every match mode, case folding
// changed mid-string, zero bytes, empty and oversized patterns; random strings
// with embedded patterns follow across three idling phases.
// ----------------------------------------------------------------------------

module tb_substring_prefix_suffix_matcher_unit;

   localparam int         WINDOW_DEPTH      = spsm_pkg::PATTERN_BYTES;
   localparam logic [1:0] MODE_UNUSED       = 2'd3;
   localparam logic [2:0] CSR_UNMAPPED_LOW  = 3'd5;
   localparam logic [2:0] CSR_UNMAPPED_HIGH = 3'd7;
   localparam logic [7:0] LOWER_FIRST       = spsm_pkg::UPPER_FIRST + spsm_pkg::FOLD_OFFSET;
   localparam logic [7:0] LOWER_LAST        = spsm_pkg::UPPER_LAST + spsm_pkg::FOLD_OFFSET;
   localparam int         PHASE_BYTES       = 290;
   localparam int         STRINGS_PER_SETUP = 8;

   // One row of the directed table: a register write or a string byte.
   typedef struct {
      bit          is_csr;
      logic [2:0]  index;
      logic [63:0] data;
      logic [7:0]  char_value;
      bit          last;
      bit          preset;
      bit          preset_match;
   } stim_row_type;

   // Where the expected match of a string comes from.
   typedef struct packed {
      bit preset;
      bit value;
   } verdict_src_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spsm_req_if req_ch ();
   spsm_rsp_if rsp_ch ();
   spsm_csr_if csr_ch ();

   substring_prefix_suffix_matcher_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Predictor copy of the configuration and the per-string state.
   logic [spsm_pkg::PATTERN_W-1:0] cfg_pattern;
   logic [4:0]                     cfg_length;
   logic [1:0]                     cfg_mode;
   logic                           cfg_fold;
   logic [7:0]                     win_hist [WINDOW_DEPTH];
   int unsigned                    seen_bytes;
   bit                             found_sticky;

   // Expected matches in arrival order, and where each one comes from.
   bit                             expected_matches [$];
   verdict_src_type                preset_verdicts [$];
   stim_row_type                   directed_rows [$];

   // Stimulus-side view of the current setting, used to embed the pattern.
   logic [spsm_pkg::PATTERN_W-1:0] stim_pattern;
   logic [4:0]                     stim_length;
   bit                             stim_fold;

   int                             send_idle_pct;
   int                             rsp_stall_pct;
   int                             bytes_sent;
   int                             mismatch_count;

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic logic [7:0] fold_byte(input logic [7:0] c);
      if (cfg_fold && c >= spsm_pkg::UPPER_FIRST && c <= spsm_pkg::UPPER_LAST) begin
         return c + spsm_pkg::FOLD_OFFSET;
      end
      return c;
   endfunction

   // True when the newest cfg_length window bytes spell the pattern.
   function automatic bit window_hit();
      if (cfg_length == 0 || cfg_length > WINDOW_DEPTH) begin
         return 1'b0;
      end
      for (int i = 0; i < cfg_length; i++) begin
         if (fold_byte(win_hist[cfg_length - 1 - i]) != fold_byte(cfg_pattern[8*i +: 8])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void clear_string();
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_hist[i] = 8'h00;
      end
      seen_bytes   = 0;
      found_sticky = 1'b0;
   endfunction

   // Shifts one byte in and reports the match when it closes a string.
   task automatic predict_match(input logic [7:0] c, input bit last,
                                output bit produces, output bit matched);
      int unsigned prior;
      bit          hit;
      prior = seen_bytes;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
         win_hist[i] = win_hist[i-1];
      end
      win_hist[0] = c;
      if (seen_bytes < WINDOW_DEPTH) begin
         seen_bytes++;
      end
      hit = cfg_length != 0 && seen_bytes >= cfg_length && window_hit();
      if (cfg_mode == spsm_pkg::MODE_CONTAINS && hit) begin
         found_sticky = 1'b1;
      end else if (cfg_mode == spsm_pkg::MODE_STARTS && hit && prior + 1 == cfg_length) begin
         found_sticky = 1'b1;
      end
      produces = last;
      matched  = 1'b0;
      if (last) begin
         case (cfg_mode)
            spsm_pkg::MODE_CONTAINS, spsm_pkg::MODE_STARTS: matched = found_sticky;
            spsm_pkg::MODE_ENDS:                            matched = hit;
            default:                                        matched = 1'b0;
         endcase
         clear_string();
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: register writes, accepted bytes and results at each edge
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      verdict_src_type src;
      bit              produces;
      bit              matched;
      bit              want;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               spsm_pkg::CSR_PATTERN_LOW:    cfg_pattern[63:0]   = csr_ch.data;
               spsm_pkg::CSR_PATTERN_HIGH:   cfg_pattern[127:64] = csr_ch.data;
               spsm_pkg::CSR_PATTERN_LENGTH: cfg_length          = csr_ch.data[4:0];
               spsm_pkg::CSR_MATCH_MODE:     cfg_mode            = csr_ch.data[1:0];
               spsm_pkg::CSR_FOLD_CASE:      cfg_fold            = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_match(req_ch.in_char, req_ch.is_last, produces, matched);
            if (produces) begin
               src = preset_verdicts.pop_front();
               expected_matches.push_back(src.preset ? src.value : matched);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, actual matched=%0b",
                        $time, rsp_ch.matched);
               mismatch_count++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_ch.matched !== want) begin
                  $display("%0t: matched mismatch, expected %0b, actual %0b",
                           $time, want, rsp_ch.matched);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] c, input bit last,
                            input bit preset, input bit preset_match);
      if (last) begin
         preset_verdicts.push_back('{preset, preset_match});
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_char <= c;
      req_ch.is_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Holds the sender back until every expected match has come and the
   // last byte has settled in the window.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) begin
         @(posedge clock);
      end
      repeat (2) @(posedge clock);
   endtask

   function automatic void add_byte_row(input logic [7:0] c, input bit last,
                                        input bit preset, input bit preset_match);
      directed_rows.push_back('{1'b0, 3'd0, 64'd0, c, last, preset, preset_match});
   endfunction

   function automatic void add_csr_row(input logic [2:0] index, input logic [63:0] data);
      directed_rows.push_back('{1'b1, index, data, 8'h00, 1'b0, 1'b0, 1'b0});
   endfunction

   // Picks a new setting; the widest flag forces a full sixteen-byte pattern.
   task automatic random_setup(input bit widest);
      logic [spsm_pkg::PATTERN_W-1:0] pat;
      logic [4:0]                     len;
      logic [1:0]                     mode;
      bit                             fold_on;
      int                             r;
      r = $urandom_range(11);
      if (widest) begin
         len = 5'd16;
      end else begin
         case (r)
            0:       len = 5'd16;
            1:       len = 5'd0;
            2:       len = 5'($urandom_range(31, 17));
            3:       len = 5'($urandom_range(15, 7));
            default: len = 5'($urandom_range(5, 1));
         endcase
      end
      mode    = ($urandom_range(15) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
      fold_on = 1'($urandom_range(1));
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if (i < len && $urandom_range(1) == 0) begin
            pat[8*i +: 8] = 8'($urandom_range(25)) +
                            (($urandom_range(1) == 0) ? spsm_pkg::UPPER_FIRST : LOWER_FIRST);
         end else if (i < len) begin
            pat[8*i +: 8] = 8'($urandom_range(255, 1));
         end else begin
            pat[8*i +: 8] = 8'($urandom_range(255));
         end
      end
      // Upper bits of the narrow registers carry random junk.
      write_reg(spsm_pkg::CSR_PATTERN_LOW, pat[63:0]);
      write_reg(spsm_pkg::CSR_PATTERN_HIGH, pat[127:64]);
      write_reg(spsm_pkg::CSR_PATTERN_LENGTH, {59'({$urandom, $urandom}), len});
      write_reg(spsm_pkg::CSR_MATCH_MODE, {62'({$urandom, $urandom}), mode});
      write_reg(spsm_pkg::CSR_FOLD_CASE, {63'({$urandom, $urandom}), fold_on});
      if ($urandom_range(5) == 0) begin
         write_reg(3'($urandom_range(CSR_UNMAPPED_HIGH, CSR_UNMAPPED_LOW)),
                   {$urandom, $urandom});
      end
      stim_pattern = pat;
      stim_length  = len;
      stim_fold    = fold_on;
   endtask

   // Sends one string; most strings carry the pattern at its start, its end
   // or somewhere inside, with letters flipped in case now and then.
   task automatic send_string();
      int         plen;
      int         slen;
      int         pos;
      bit         embed;
      logic [7:0] ch;
      plen  = (stim_length >= 1 && stim_length <= WINDOW_DEPTH) ? stim_length : 0;
      embed = plen != 0 && $urandom_range(9) < 7;
      if (embed) begin
         slen = plen + (($urandom_range(7) == 0) ? $urandom_range(8, 5) : $urandom_range(4));
         case ($urandom_range(2))
            0:       pos = 0;
            1:       pos = slen - plen;
            default: pos = $urandom_range(slen - plen);
         endcase
      end else begin
         slen = ($urandom_range(7) == 0) ? $urandom_range(20, 11) : $urandom_range(10, 1);
         pos  = 0;
      end
      for (int k = 0; k < slen; k++) begin
         if (embed && k >= pos && k < pos + plen) begin
            ch = stim_pattern[8*(k - pos) +: 8];
         end else if ($urandom_range(1) == 0) begin
            ch = stim_pattern[8*$urandom_range(WINDOW_DEPTH - 1) +: 8];
         end else begin
            ch = 8'($urandom_range(255, 1));
         end
         if (((ch >= spsm_pkg::UPPER_FIRST && ch <= spsm_pkg::UPPER_LAST) ||
              (ch >= LOWER_FIRST && ch <= LOWER_LAST))
             && $urandom_range(stim_fold ? 3 : 15) == 0) begin
            ch = ch ^ spsm_pkg::FOLD_OFFSET;
         end
         if (ch == 8'h00) begin
            ch = 8'h01;
         end
         send_byte(ch, k == slen - 1, 1'b0, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------

   initial begin
      int start_bytes;
      int seg;
      int drain_cycles;
      req_ch.valid   = 1'b0;
      req_ch.in_char = 8'h00;
      req_ch.is_last = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = spsm_pkg::CSR_PATTERN_LOW;
      csr_ch.data    = 64'd0;
      rsp_ch.ready   = 1'b0;
      cfg_pattern    = '0;
      cfg_length     = '0;
      cfg_mode       = '0;
      cfg_fold       = 1'b0;
      clear_string();
      bytes_sent     = 0;
      mismatch_count = 0;
      send_idle_pct  = 30;
      rsp_stall_pct  = 62;

      // Directed table. Empty pattern straight after reset.
      add_byte_row("a", 1'b1, 1'b1, 1'b0);
      // Contains "abc".
      add_csr_row(spsm_pkg::CSR_PATTERN_LOW, 64'h0000_0000_0063_6261);
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd3);
      add_byte_row("x", 1'b0, 1'b0, 1'b0);
      add_byte_row("a", 1'b0, 1'b0, 1'b0);
      add_byte_row("b", 1'b0, 1'b0, 1'b0);
      add_byte_row("c", 1'b1, 1'b0, 1'b0);
      // Starts with "abc", then a string shorter than the pattern.
      add_csr_row(spsm_pkg::CSR_MATCH_MODE, 64'(spsm_pkg::MODE_STARTS));
      add_byte_row("a", 1'b0, 1'b0, 1'b0);
      add_byte_row("b", 1'b0, 1'b0, 1'b0);
      add_byte_row("c", 1'b0, 1'b0, 1'b0);
      add_byte_row("d", 1'b1, 1'b0, 1'b0);
      add_byte_row("a", 1'b0, 1'b0, 1'b0);
      add_byte_row("b", 1'b1, 1'b1, 1'b0);
      // Ends with "ab", with case folding switched on between two bytes.
      add_csr_row(spsm_pkg::CSR_MATCH_MODE, 64'(spsm_pkg::MODE_ENDS));
      add_csr_row(spsm_pkg::CSR_PATTERN_LOW, 64'h0000_0000_0000_6261);
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd2);
      add_byte_row("A", 1'b0, 1'b0, 1'b0);
      add_csr_row(spsm_pkg::CSR_FOLD_CASE, 64'd1);
      add_byte_row("B", 1'b1, 1'b0, 1'b0);
      // Zero bytes on both sides are ordinary bytes; extremes of the byte.
      add_csr_row(spsm_pkg::CSR_PATTERN_LOW, 64'h0000_0000_00FF_0001);
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd3);
      add_csr_row(spsm_pkg::CSR_MATCH_MODE, 64'(spsm_pkg::MODE_CONTAINS));
      add_byte_row(8'h7F, 1'b0, 1'b0, 1'b0);
      add_byte_row(8'h01, 1'b0, 1'b0, 1'b0);
      add_byte_row(8'h00, 1'b0, 1'b0, 1'b0);
      add_byte_row(8'hFF, 1'b1, 1'b0, 1'b0);
      // Pattern longer than the window never matches.
      add_csr_row(spsm_pkg::CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd17);
      add_byte_row(8'h80, 1'b1, 1'b1, 1'b0);
      // Empty pattern written explicitly.
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd0);
      add_byte_row("z", 1'b1, 1'b1, 1'b0);
      // The unused mode never matches, even on an exact hit.
      add_csr_row(spsm_pkg::CSR_PATTERN_LOW, 64'h0000_0000_0000_007A);
      add_csr_row(spsm_pkg::CSR_PATTERN_LENGTH, 64'd1);
      add_csr_row(spsm_pkg::CSR_MATCH_MODE, 64'(MODE_UNUSED));
      add_byte_row("z", 1'b1, 1'b1, 1'b0);
      // Writes to unmapped indexes change nothing.
      add_csr_row(CSR_UNMAPPED_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      add_csr_row(CSR_UNMAPPED_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      add_byte_row("z", 1'b1, 1'b1, 1'b0);
      add_csr_row(spsm_pkg::CSR_FOLD_CASE, 64'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_for_results();
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_byte(directed_rows[i].char_value, directed_rows[i].last,
                      directed_rows[i].preset, directed_rows[i].preset_match);
         end
      end

      // Random strings in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 30;
               rsp_stall_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               rsp_stall_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         start_bytes = bytes_sent;
         seg = 0;
         while (bytes_sent - start_bytes < PHASE_BYTES) begin
            wait_for_results();
            random_setup(seg == 0);
            for (int s = 0; s < STRINGS_PER_SETUP; s++) begin
               send_string();
               if ($urandom_range(24) == 0) begin
                  wait_for_results();
               end
            end
            seg++;
         end
      end

      // Let the remaining results drain.
      req_ch.valid <= 1'b0;
      @(posedge clock);
      drain_cycles = 0;
      while (expected_matches.size() != 0 && drain_cycles < 1000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (4) @(posedge clock);
      if (expected_matches.size() != 0) begin
         $display("%0t: results missing at the end, expected %0d more, actual 0",
                  $time, expected_matches.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/spsm_pkg.sv
sv/spsm_intf.sv
sv/spsm_cell.sv
sv/substring_prefix_suffix_matcher_unit.sv
tb/sv/tb_substring_prefix_suffix_matcher_unit.sv
